>>> hw/rtl/bitmap_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// bitmap block allocator assertion macros
// concurrent assertion forms used by bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BBA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, codes and types of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int MAX_BLOCKS_DEF  = 4096;
   localparam int BLOCK_BYTES_DEF = 512;

   localparam int ADDR_W    = 32;
   localparam int COUNT_W   = 13;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam int STATUS_W  = 2;

   localparam logic [7:0] FULL_BYTE = 8'hFF;
   localparam logic [7:0] ONE_BIT   = 8'h01;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MULT,
      ST_SUM,
      ST_DIV,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              done;
      logic              rem_zero;
      logic [ADDR_W-1:0] quotient;
   } div_result_type;

endpackage

>>> hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bba_divider.sv
// ----------------------------------------------------------------------------
// bba_divider
// divide by a fixed block size through a reciprocal multiply
// ----------------------------------------------------------------------------
module bba_divider import bba_pkg::*; #(
   parameter int DIVISOR = BLOCK_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   output div_result_type    result
);

   // (n * RECIP) >> SHIFT is the exact quotient for every 32-bit n
   localparam int DIV_BITS = $clog2(DIVISOR);
   localparam int SHIFT    = ADDR_W + DIV_BITS;
   localparam int RW       = ADDR_W + 1;
   localparam int HALF     = ADDR_W / 2;
   localparam int PW       = HALF + RW;      // half-word partial product
   localparam int SW       = ADDR_W + RW;    // full product
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

   logic [3:0]        stage_ff, stage_in;   // progress through the pipeline
   logic              done_ff, done_in;
   logic [ADDR_W-1:0] dvd_ff, dvd_in;
   logic [PW-1:0]     lo_prod_ff, lo_prod_in;
   logic [PW-1:0]     hi_prod_ff, hi_prod_in;
   logic [ADDR_W-1:0] quot_ff, quot_in;
   logic [ADDR_W-1:0] back_ff, back_in;
   logic [SW-1:0]     full_prod;

   assign full_prod = {hi_prod_ff, {HALF{1'b0}}} + SW'(lo_prod_ff);

   always_comb begin
      stage_in   = {stage_ff[2:0], start};
      done_in    = stage_ff[3];
      dvd_in     = start ? dividend : dvd_ff;
      // low and high halves of the dividend times the reciprocal
      lo_prod_in = stage_ff[0] ? PW'(dvd_ff[HALF-1:0]) * PW'(RECIP) : lo_prod_ff;
      hi_prod_in = stage_ff[1] ? PW'(dvd_ff[ADDR_W-1:HALF]) * PW'(RECIP) : hi_prod_ff;
      quot_in    = stage_ff[2] ? ADDR_W'(full_prod >> SHIFT) : quot_ff;
      // quotient times divisor equals the dividend only when nothing is left over
      back_in    = stage_ff[3] ? ADDR_W'(quot_ff * ADDR_W'(DIVISOR)) : back_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      dvd_ff     <= dvd_in;
      lo_prod_ff <= lo_prod_in;
      hi_prod_ff <= hi_prod_in;
      quot_ff    <= quot_in;
      back_ff    <= back_in;
   end

   assign result.done     = done_ff;
   assign result.rem_zero = (back_ff == dvd_ff);
   assign result.quotient = quot_ff;

endmodule

>>> hw/rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit allocator over a used/free bitmap of fixed-size memory blocks
// ----------------------------------------------------------------------------
// usage:
//   req channel: one beat per command, tuser[0] is the opcode (0 allocate,
//   1 free), tdata the byte address to free. rsp channel: one beat per
//   command, tuser the status (done, full, bad address), tdata the
//   allocated address or zero. csr port: index 0 entry_count, index 1
//   region_base; write only while no command is outstanding.
// sequencing, one command at a time; req_tready returns together with rsp valid:
//   allocate: the bitmap bytes are scanned from byte 0, one byte read per cycle,
//   then the first clear bit is set and region_base + index * BLOCK_BYTES formed;
//   no free block: full once all lim whole bytes are scanned (at once when zero);
//   at most 512 bytes by default. free: reciprocal divide of the offset, then a
//   read and write of a written byte; rejected after the divide or below region_base.
// reset: the bitmap reads as all free and the registers as zero at once;
//   a fill count marks the written prefix of the ram, so no clearing pass.
// stall: a finished result waits in the rsp register; the next command
//   is taken meanwhile and its own result is held until the slot frees.
module bitmap_block_allocator import bba_pkg::*; #(
   parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request beats
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ADDR_W-1:0]    req_tdata,   // [31:0] free_address
   input  logic [0:0]           req_tuser,   // [0] opcode
   // response beats
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [ADDR_W-1:0]    rsp_tdata,   // [31:0] block_address
   output logic [STATUS_W-1:0]  rsp_tuser,   // [1:0] status
   // register writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   localparam int MAP_BYTES  = MAX_BLOCKS / 8;
   localparam int AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int LW         = $clog2(MAP_BYTES + 1);   // holds a byte count
   localparam int IW         = LW + 3;                  // block index
   localparam int FREE_LIMIT = MAP_BYTES * 8;

   // lowest clear bit of a bitmap byte
   function automatic logic [2:0] lowest_zero(input logic [7:0] v);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!v[i]) r = 3'(i);
      end
      return r;
   endfunction

   // control and config state
   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [ADDR_W-1:0]   region_base_ff, region_base_in;
   logic [LW-1:0]       fill_ff, fill_in;        // bytes of the ram written so far
   logic [LW-1:0]       lim_ff, lim_in;          // bytes to scan
   logic [LW-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [LW-1:0]       chk_ptr_ff, chk_ptr_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [ADDR_W-1:0]   prod_ff, prod_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;

   // ram and divider hookup
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [7:0]          ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [7:0]          ram_rd_data;
   logic                div_start;
   logic [ADDR_W-1:0]   div_dividend;
   div_result_type      div_res;

   // helpers
   logic [LW-1:0]       lim_now;
   logic [ADDR_W-1:0]   free_lim;
   logic [7:0]          byte_val;
   logic [2:0]          zero_bit;
   logic [IW-1:0]       q_idx;
   logic [LW-1:0]       q_byte;
   logic [LW-1:0]       idx_byte;

   bba_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bba_divider #(
      .DIVISOR (BLOCK_BYTES)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .result   (div_res)
   );

   // whole bitmap bytes below entry_count, capped at the ram depth
   assign lim_now = (32'(entry_count_ff[COUNT_W-1:3]) > 32'(MAP_BYTES)) ?
                    LW'(MAP_BYTES) : LW'(entry_count_ff[COUNT_W-1:3]);
   // highest freeable index plus one
   assign free_lim = (32'(entry_count_ff) > 32'(FREE_LIMIT)) ?
                     32'(FREE_LIMIT) : 32'(entry_count_ff);

   // bytes past the fill count were never written and read as free
   assign byte_val = (chk_ptr_ff < fill_ff) ? ram_rd_data : 8'h00;
   assign zero_bit = lowest_zero(byte_val);
   assign q_idx    = div_res.quotient[IW-1:0];
   assign q_byte   = q_idx[IW-1:3];
   assign idx_byte = idx_ff[IW-1:3];

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      region_base_in = region_base_ff;
      fill_in        = fill_ff;
      lim_in         = lim_ff;
      scan_ptr_in    = scan_ptr_ff;
      chk_ptr_in     = chk_ptr_ff;
      chk_valid_in   = 1'b0;
      idx_in         = idx_ff;
      prod_in        = prod_ff;
      res_status_in  = res_status_ff;
      res_addr_in    = res_addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;
      div_start      = 1'b0;
      div_dividend   = req_tdata - region_base_ff;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ENTRY_COUNT: entry_count_in = csr_wr_data[COUNT_W-1:0];
            CSR_REGION_BASE: region_base_in = csr_wr_data[ADDR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_addr_in = '0;
               if (req_tuser[0] == OP_ALLOC) begin
                  lim_in      = lim_now;
                  scan_ptr_in = '0;
                  if (lim_now == '0) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (req_tdata < region_base_ff) begin
                  res_status_in = STATUS_BAD_ADDR;
                  state_in      = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end

         ST_SCAN: begin
            // one read issued and one byte checked per cycle
            if (chk_valid_ff && byte_val != FULL_BYTE) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = chk_ptr_ff[AW-1:0];
               ram_wr_data = byte_val | 8'(ONE_BIT << zero_bit);
               if (chk_ptr_ff == fill_ff) begin
                  fill_in = fill_ff + LW'(1);
               end
               idx_in   = {chk_ptr_ff, zero_bit};
               state_in = ST_MULT;
            end else if (chk_valid_ff && chk_ptr_ff == lim_ff - LW'(1)) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_DONE;
            end else if (scan_ptr_ff < lim_ff) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = scan_ptr_ff[AW-1:0];
               chk_valid_in = 1'b1;
               chk_ptr_in   = scan_ptr_ff;
               scan_ptr_in  = scan_ptr_ff + LW'(1);
            end
         end

         ST_MULT: begin
            prod_in  = 32'(idx_ff) * 32'(BLOCK_BYTES);
            state_in = ST_SUM;
         end

         ST_SUM: begin
            res_status_in = STATUS_DONE;
            res_addr_in   = region_base_ff + prod_ff;
            state_in      = ST_DONE;
         end

         ST_DIV: begin
            if (div_res.done) begin
               if (!div_res.rem_zero || div_res.quotient >= free_lim) begin
                  res_status_in = STATUS_BAD_ADDR;
                  state_in      = ST_DONE;
               end else if (q_byte >= fill_ff) begin
                  // never written, bit is already clear
                  res_status_in = STATUS_DONE;
                  state_in      = ST_DONE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = q_byte[AW-1:0];
                  idx_in      = q_idx;
                  state_in    = ST_FREE_WR;
               end
            end
         end

         ST_FREE_WR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = idx_byte[AW-1:0];
            ram_wr_data   = ram_rd_data & ~8'(ONE_BIT << idx_ff[2:0]);
            res_status_in = STATUS_DONE;
            state_in      = ST_DONE;
         end

         ST_DONE: begin
            // hand over once the output slot is empty or draining
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         region_base_ff <= '0;
         fill_ff        <= '0;
         chk_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         region_base_ff <= region_base_in;
         fill_ff        <= fill_in;
         chk_valid_ff   <= chk_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      lim_ff        <= lim_in;
      scan_ptr_ff   <= scan_ptr_in;
      chk_ptr_ff    <= chk_ptr_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

`include "bitmap_block_allocator_defines.svh"

   // fill count never runs past the ram
   `BBA_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= LW'(MAP_BYTES), "fill past depth")
   // writes stay inside the written prefix or extend it by one byte
   `BBA_ASSERT_IMPL(a_wr_prefix, clock, reset, ram_wr_en, LW'(ram_wr_addr) <= fill_ff, "write gap")
   // scan pointer stays within the scan window
   `BBA_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == ST_SCAN, scan_ptr_ff <= lim_ff, "scan overrun")
   // divider only finishes while its result is awaited
   `BBA_ASSERT_IMPL(a_div_state, clock, reset, div_res.done, state_ff == ST_DIV, "stray divide")
   // a held result waits while the output slot is stalled
   `BBA_ASSERT_NEXT(a_rsp_hold, clock, reset, state_ff == ST_DONE && rsp_valid_ff && !rsp_tready, state_ff == ST_DONE, "result dropped")

endmodule
